// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the pixel blend core.
// Needs nothing else; take it in by include before the first use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define MMPB_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MMPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmpb_pkg.sv =====
// Types and constants for the masked multi-view pixel blend core.
// No dependencies; the interfaces, the design modules and the bench import it.
`timescale 1ns / 1ps
`default_nettype none
package mmpb_pkg;

  localparam int MAX_VIEWS  = 4;
  localparam int CHANNELS   = 3;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 24;
  localparam int MASK_W     = 2;
  localparam int DEPTH_W    = 16;
  localparam int DIST_W     = 16;
  localparam int CNT_W      = 3;
  localparam int SUM_W      = 18;
  localparam int W_W        = 18;
  localparam int PROD_W     = 26;
  localparam int DEN_W      = 20;
  localparam int NUM_W      = 28;
  localparam int DIV_STAGES = 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [MASK_W-1:0] MASK_EMPTY    = 2'd0;
  localparam logic [MASK_W-1:0] MASK_UNSTABLE = 2'd1;

  localparam logic [2:0] REG_VIEW_COUNT = 3'd0;
  localparam logic [2:0] REG_DIST0      = 3'd1;
  localparam logic [2:0] REG_DIST3      = 3'd4;

  localparam logic [CNT_W-1:0]  VIEW_COUNT_RESET = 3'd2;
  localparam logic [DIST_W-1:0] DIST_RESET       = 16'd256;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [MASK_W-1:0]  mask;
    logic [DEPTH_W-1:0] depth;
  } view_t;

  typedef struct packed {
    logic [CNT_W-1:0]                  view_count;
    logic [MAX_VIEWS-1:0][DIST_W-1:0]  cam_dist;
  } cfg_t;

  typedef struct packed {
    logic [MAX_VIEWS-1:0]              take;
    logic [MAX_VIEWS-1:0][COLOR_W-1:0] color;
    logic [MAX_VIEWS-1:0][DIST_W-1:0]  cam_dist;
    logic [DEPTH_W-1:0]                depth;
    logic [CNT_W-1:0]                  k;
    logic                              set;
  } sel_t;

  typedef struct packed {
    sel_t              sel;
    logic [SUM_W-1:0]  sum;
  } sum_t;

  typedef struct packed {
    logic [MAX_VIEWS-1:0][W_W-1:0]     w;
    logic [MAX_VIEWS-1:0][COLOR_W-1:0] color;
    logic [DEPTH_W-1:0]                depth;
    logic                              set;
  } wgt_t;

  typedef struct packed {
    logic [CHANNELS-1:0][MAX_VIEWS-1:0][PROD_W-1:0] prod;
    logic [DEN_W-1:0]                               den;
    logic [DEPTH_W-1:0]                             depth;
    logic                                           set;
  } prod_t;

  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]               den;
    logic [DEPTH_W-1:0]             depth;
    logic                           set;
  } acc_t;

  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0] rem;
    logic [CHANNELS-1:0][CH_W-1:0]  q;
    logic [DEN_W-1:0]               den;
    logic [DEPTH_W-1:0]             depth;
    logic                           set;
  } div_t;

  typedef struct packed {
    logic [CHANNELS-1:0][CH_W-1:0] q;
    logic [DEPTH_W-1:0]            depth;
    logic                          set;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/mmpb_ifs.sv =====
// Stream channels of the pixel blend core: per-view pixel beats in, blended beats out.
// Depends on mmpb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mmpb_view_if;
  import mmpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] view0_color;
  logic [MASK_W-1:0]  view0_mask;
  logic [DEPTH_W-1:0] view0_depth;
  logic [COLOR_W-1:0] view1_color;
  logic [MASK_W-1:0]  view1_mask;
  logic [DEPTH_W-1:0] view1_depth;
  logic [COLOR_W-1:0] view2_color;
  logic [MASK_W-1:0]  view2_mask;
  logic [DEPTH_W-1:0] view2_depth;
  logic [COLOR_W-1:0] view3_color;
  logic [MASK_W-1:0]  view3_mask;
  logic [DEPTH_W-1:0] view3_depth;

  modport source (
    output valid, view0_color, view0_mask, view0_depth, view1_color, view1_mask,
           view1_depth, view2_color, view2_mask, view2_depth, view3_color,
           view3_mask, view3_depth,
    input  ready
  );
  modport sink (
    input  valid, view0_color, view0_mask, view0_depth, view1_color, view1_mask,
           view1_depth, view2_color, view2_mask, view2_depth, view3_color,
           view3_mask, view3_depth,
    output ready
  );
endinterface

interface mmpb_blend_if;
  import mmpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] out_color;
  logic               out_set;
  logic [DEPTH_W-1:0] out_depth;

  modport source (output valid, out_color, out_set, out_depth, input ready);
  modport sink (input valid, out_color, out_set, out_depth, output ready);
endinterface
`default_nettype wire

// ===== rtl/mmpb_cfg.sv =====
// APB register file: view count and the four per-view distances.
// Depends on mmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmpb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmpb_pkg::ADDR_W-1:0] paddr,
  input  logic [mmpb_pkg::DATA_W-1:0] pwdata,
  output logic [mmpb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mmpb_pkg::cfg_t              cfg
);
  import mmpb_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_count <= VIEW_COUNT_RESET;
      for (int v = 0; v < MAX_VIEWS; v++) begin
        cfg.cam_dist[v] <= DIST_RESET;
      end
    end else if (wr) begin
      unique case (idx) inside
        REG_VIEW_COUNT:        cfg.view_count <= pwdata[CNT_W-1:0];
        [REG_DIST0:REG_DIST3]: cfg.cam_dist[2'(idx - REG_DIST0)] <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      REG_VIEW_COUNT:        prdata = DATA_W'(cfg.view_count);
      [REG_DIST0:REG_DIST3]: prdata = DATA_W'(cfg.cam_dist[2'(idx - REG_DIST0)]);
      default:               prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/mmpb_select.sv =====
// View selection (two stages): mask filtering, contributor count, depth pick,
// then the distance sum. Depends on mmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmpb_select #(
  parameter int VIEWS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  mmpb_pkg::view_t [mmpb_pkg::MAX_VIEWS-1:0] views,
  input  mmpb_pkg::cfg_t                      cfg,
  output logic                                sum_valid,
  output mmpb_pkg::sum_t                      sum_out
);
  import mmpb_pkg::*;

  localparam logic [CNT_W-1:0] VIEWS_N = CNT_W'(VIEWS);

  logic [CNT_W-1:0]     nv;
  logic [MAX_VIEWS-1:0] active;
  logic                 stable_seen;
  logic                 take;
  sel_t                 sel_next;
  sel_t                 sel;
  logic                 sel_valid;
  sum_t                 sum_next;

  always_comb begin
    if (cfg.view_count == '0) begin
      nv = CNT_W'(1);
    end else if (cfg.view_count > VIEWS_N) begin
      nv = VIEWS_N;
    end else begin
      nv = cfg.view_count;
    end
    stable_seen = 1'b0;
    for (int v = 0; v < MAX_VIEWS; v++) begin
      active[v] = (v < VIEWS) && (CNT_W'(v) < nv);
      if (active[v] && views[v].mask != MASK_EMPTY && views[v].mask != MASK_UNSTABLE) begin
        stable_seen = 1'b1;
      end
    end
    sel_next       = '0;
    take           = 1'b0;
    for (int v = 0; v < MAX_VIEWS; v++) begin
      take = active[v] && (views[v].mask != MASK_EMPTY) &&
             !((views[v].mask == MASK_UNSTABLE) && stable_seen);
      sel_next.take[v]     = take;
      sel_next.color[v]    = views[v].color;
      sel_next.cam_dist[v] = take ? cfg.cam_dist[v] : '0;
      if (take) begin
        sel_next.depth = views[v].depth;
        sel_next.k     = sel_next.k + CNT_W'(1);
      end
    end
    sel_next.set = (sel_next.take != '0);
  end

  always_comb begin
    sum_next.sel = sel;
    sum_next.sum = '0;
    for (int v = 0; v < MAX_VIEWS; v++) begin
      sum_next.sum = sum_next.sum + SUM_W'(sel.cam_dist[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      sel_valid <= in_valid;
      sum_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel     <= sel_next;
      sum_out <= sum_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mmpb_weight.sv =====
// Weighting (three stages): per-view weights, weight times channel products
// with the weight sum, then per-channel numerators. Depends on mmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmpb_weight (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           sum_valid,
  input  mmpb_pkg::sum_t sum_in,
  output logic           acc_valid,
  output mmpb_pkg::acc_t acc
);
  import mmpb_pkg::*;

  logic  uniform;
  wgt_t  wgt_next;
  wgt_t  wgt;
  logic  wgt_valid;
  prod_t prod_next;
  prod_t prod;
  logic  prod_valid;
  acc_t  acc_next;

  // equal weights when the distances sum to zero or a single view contributes
  always_comb begin
    uniform = (sum_in.sum == '0) || (sum_in.sel.k == CNT_W'(1));
    wgt_next.color = sum_in.sel.color;
    wgt_next.depth = sum_in.sel.depth;
    wgt_next.set   = sum_in.sel.set;
    for (int v = 0; v < MAX_VIEWS; v++) begin
      if (!sum_in.sel.take[v]) begin
        wgt_next.w[v] = '0;
      end else if (uniform) begin
        wgt_next.w[v] = W_W'(1);
      end else begin
        wgt_next.w[v] = W_W'(sum_in.sum) - W_W'(sum_in.sel.cam_dist[v]);
      end
    end
  end

  always_comb begin
    prod_next.depth = wgt.depth;
    prod_next.set   = wgt.set;
    prod_next.den   = '0;
    for (int v = 0; v < MAX_VIEWS; v++) begin
      prod_next.den = prod_next.den + DEN_W'(wgt.w[v]);
      for (int c = 0; c < CHANNELS; c++) begin
        prod_next.prod[c][v] = PROD_W'(wgt.w[v]) * PROD_W'(wgt.color[v][c*CH_W +: CH_W]);
      end
    end
  end

  always_comb begin
    acc_next.den   = prod.den;
    acc_next.depth = prod.depth;
    acc_next.set   = prod.set;
    for (int c = 0; c < CHANNELS; c++) begin
      acc_next.num[c] = '0;
      for (int v = 0; v < MAX_VIEWS; v++) begin
        acc_next.num[c] = acc_next.num[c] + NUM_W'(prod.prod[c][v]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wgt_valid  <= 1'b0;
      prod_valid <= 1'b0;
      acc_valid  <= 1'b0;
    end else if (adv) begin
      wgt_valid  <= sum_valid;
      prod_valid <= wgt_valid;
      acc_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wgt  <= wgt_next;
      prod <= prod_next;
      acc  <= acc_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mmpb_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for all three
// channels at once, eight stages. Depends on mmpb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmpb_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           acc_valid,
  input  mmpb_pkg::acc_t acc,
  output logic           res_valid,
  output mmpb_pkg::res_t res
);
  import mmpb_pkg::*;

  div_t st  [DIV_STAGES];
  logic vld [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - j;
    div_t             src;
    div_t             nxt;
    logic             src_valid;
    logic [NUM_W-1:0] dsh;

    if (j == 0) begin : g_first
      always_comb begin
        src.rem   = acc.num;
        src.q     = '0;
        src.den   = acc.den;
        src.depth = acc.depth;
        src.set   = acc.set;
        src_valid = acc_valid;
      end
    end else begin : g_next
      always_comb begin
        src       = st[j-1];
        src_valid = vld[j-1];
      end
    end

    always_comb begin
      nxt = src;
      dsh = NUM_W'(src.den) << B;
      for (int c = 0; c < CHANNELS; c++) begin
        if (src.rem[c] >= dsh) begin
          nxt.rem[c]  = src.rem[c] - dsh;
          nxt.q[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nxt;
      end
    end
  end

  assign res_valid = vld[DIV_STAGES-1];
  assign res.q     = st[DIV_STAGES-1].q;
  assign res.depth = st[DIV_STAGES-1].depth;
  assign res.set   = st[DIV_STAGES-1].set;
endmodule
`default_nettype wire

// ===== rtl/masked_multiview_pixel_blend_core.sv =====
// Pipeline: 2 select stages, 3 weighting stages and 8 divider stages lie between
// an accepted input beat and its output beat.
// Throughput: one pixel per cycle; the whole pipeline holds while the last
// stage carries a beat that the sink does not take.
// Reset: clears all stage valid bits; view_count returns to 2, distances to 256.
`timescale 1ns / 1ps
`default_nettype none
module masked_multiview_pixel_blend_core #(
  parameter int VIEWS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmpb_pkg::ADDR_W-1:0] paddr,
  input  logic [mmpb_pkg::DATA_W-1:0] pwdata,
  output logic [mmpb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  mmpb_view_if.sink                   views,
  mmpb_blend_if.source                blend
);
  import mmpb_pkg::*;

  cfg_t                     cfg;
  view_t [MAX_VIEWS-1:0]    view_arr;
  logic                     adv;
  logic                     sum_valid;
  sum_t                     sum_st;
  logic                     acc_valid;
  acc_t                     acc;
  logic                     res_valid;
  res_t                     res;

  assign view_arr[0] = '{color: views.view0_color, mask: views.view0_mask,
                         depth: views.view0_depth};
  assign view_arr[1] = '{color: views.view1_color, mask: views.view1_mask,
                         depth: views.view1_depth};
  assign view_arr[2] = '{color: views.view2_color, mask: views.view2_mask,
                         depth: views.view2_depth};
  assign view_arr[3] = '{color: views.view3_color, mask: views.view3_mask,
                         depth: views.view3_depth};

  // advance every stage unless the output beat is stalled
  assign adv         = !res_valid || blend.ready;
  assign views.ready = adv;

  mmpb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mmpb_select #(.VIEWS(VIEWS)) u_select (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (views.valid),
    .views     (view_arr),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_out   (sum_st)
  );

  mmpb_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sum_valid (sum_valid),
    .sum_in    (sum_st),
    .acc_valid (acc_valid),
    .acc       (acc)
  );

  mmpb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .acc_valid (acc_valid),
    .acc       (acc),
    .res_valid (res_valid),
    .res       (res)
  );

  assign blend.valid     = res_valid;
  assign blend.out_set   = res.set;
  assign blend.out_color = res.set ? res.q : '0;
  assign blend.out_depth = res.set ? res.depth : '0;
endmodule
`default_nettype wire

// ===== rtl/mmpb_chk.sv =====
// Port-level checker for the pixel blend core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mmpb_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_color,
  input logic        out_set,
  input logic [15:0] out_depth
);
  `MMPB_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(out_set) && $stable(out_depth), "output beat changed while stalled")
  `MMPB_ASSERT_RST(a_clear_zero, clk, rst, out_valid && !out_set |-> out_color == 24'd0 && out_depth == 16'd0, "clear output beat carries data")
  `MMPB_ASSERT_RST(a_ready_free, clk, rst, !out_valid || out_ready |-> in_ready, "input held while output side is free")
  `MMPB_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "output beat right after reset")
endmodule

bind masked_multiview_pixel_blend_core mmpb_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (views.ready),
  .out_valid (blend.valid),
  .out_ready (blend.ready),
  .out_color (blend.out_color),
  .out_set   (blend.out_set),
  .out_depth (blend.out_depth)
);
`default_nettype wire

// ===== dv/masked_multiview_pixel_blend_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the masked multi-view pixel blend core: streams views, checks blends.
// Depends on mmpb_pkg, the stream interfaces in mmpb_ifs and the core itself.
module masked_multiview_pixel_blend_core_test;
  import mmpb_pkg::*;

  localparam int VIEWS = 4;
  localparam int ITEMS_PER_SETTING = 120;
  localparam int SETTINGS = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [MASK_W-1:0] MASK_STABLE = 2'd2;
  localparam logic [MASK_W-1:0] MASK_RESERVED = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               set;
    logic [DEPTH_W-1:0] depth;
  } blend_px_t;

  class blend_scoreboard;
    logic [CNT_W-1:0]  view_count;
    logic [DIST_W-1:0] distance [MAX_VIEWS];
    blend_px_t         pending_pixels [$];
    int unsigned       errors, cleared, passed, blended, flat;

    function new();
      view_count = VIEW_COUNT_RESET;
      foreach (distance[i]) distance[i] = DIST_RESET;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      if (idx == REG_VIEW_COUNT) view_count = value[CNT_W-1:0];
      else if (idx >= REG_DIST0 && idx <= REG_DIST3) distance[idx - REG_DIST0] = value[DIST_W-1:0];
    endfunction

    function blend_px_t blend_pixel(view_t px [MAX_VIEWS]);
      blend_px_t          res;
      int unsigned        n, k;
      int                 v, i, c;
      bit                 stable_seen;
      bit [COLOR_W-1:0]   colors [MAX_VIEWS];
      longint unsigned    dists [MAX_VIEWS];
      longint unsigned    sum_d, w, num, den, q;
      res = '0;
      n = view_count;
      if (n < 1) n = 1;
      if (n > VIEWS) n = VIEWS;
      stable_seen = 0;
      k = 0;
      sum_d = 0;
      for (v = 0; v < n; v++)
        if (px[v].mask != MASK_EMPTY && px[v].mask != MASK_UNSTABLE) stable_seen = 1;
      for (v = 0; v < n; v++) begin
        if (px[v].mask == MASK_EMPTY || (px[v].mask == MASK_UNSTABLE && stable_seen)) continue;
        colors[k] = px[v].color;
        dists[k] = distance[v];
        sum_d += distance[v];
        res.depth = px[v].depth;
        k++;
      end
      if (k == 0) begin
        cleared++;
        return '0;
      end
      res.set = 1'b1;
      if (k == 1) begin
        passed++;
        res.color = colors[0];
        return res;
      end
      blended++;
      if (sum_d == 0) flat++;
      for (c = 0; c < CHANNELS; c++) begin
        num = 0;
        den = 0;
        for (i = 0; i < k; i++) begin
          w = (sum_d == 0) ? 1 : sum_d - dists[i];
          num += w * colors[i][8*c +: 8];
          den += w;
        end
        q = (den == 0) ? 0 : num / den;
        if (q > 255) q = 255;
        res.color[8*c +: 8] = q[7:0];
      end
      return res;
    endfunction

    function void note_pixel(view_t px [MAX_VIEWS]);
      pending_pixels.insert(pending_pixels.size(), blend_pixel(px));
    endfunction

    function void check_blend(blend_px_t got);
      blend_px_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected blend beat color=%h set=%b depth=%h",
                 $time, got.color, got.set, got.depth);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.color !== want.color) begin
        $display("%0t: out_color expected %h actual %h", $time, want.color, got.color);
        errors++;
      end
      if (got.set !== want.set) begin
        $display("%0t: out_set expected %b actual %b", $time, want.set, got.set);
        errors++;
      end
      if (got.depth !== want.depth) begin
        $display("%0t: out_depth expected %h actual %h", $time, want.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  bit                steady;
  int unsigned       idle_cycles;
  int unsigned       sent;
  view_t             seen [MAX_VIEWS];
  blend_scoreboard   sb;

  mmpb_view_if  views_ch();
  mmpb_blend_if blend_ch();

  masked_multiview_pixel_blend_core #(.VIEWS(VIEWS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .views(views_ch), .blend(blend_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) blend_ch.ready = steady || ($urandom_range(99) >= 6);

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (views_ch.valid && views_ch.ready) begin
        seen[0] = {views_ch.view0_color, views_ch.view0_mask, views_ch.view0_depth};
        seen[1] = {views_ch.view1_color, views_ch.view1_mask, views_ch.view1_depth};
        seen[2] = {views_ch.view2_color, views_ch.view2_mask, views_ch.view2_depth};
        seen[3] = {views_ch.view3_color, views_ch.view3_mask, views_ch.view3_depth};
        sb.note_pixel(seen);
      end
      if (blend_ch.valid && blend_ch.ready)
        sb.check_blend({blend_ch.out_color, blend_ch.out_set, blend_ch.out_depth});
      if ((views_ch.valid && views_ch.ready) || (blend_ch.valid && blend_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic view_t random_view();
    view_t v;
    int    r, c;
    r = $urandom_range(99);
    v.mask = (r < 20) ? MASK_EMPTY : (r < 55) ? MASK_UNSTABLE :
             (r < 95) ? MASK_STABLE : MASK_RESERVED;
    for (c = 0; c < CHANNELS; c++) begin
      r = $urandom_range(9);
      v.color[8*c +: 8] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    end
    v.depth = DEPTH_W'($urandom);
    return v;
  endfunction

  task automatic drive_views(input view_t px [MAX_VIEWS]);
    {views_ch.view0_color, views_ch.view0_mask, views_ch.view0_depth} = px[0];
    {views_ch.view1_color, views_ch.view1_mask, views_ch.view1_depth} = px[1];
    {views_ch.view2_color, views_ch.view2_mask, views_ch.view2_depth} = px[2];
    {views_ch.view3_color, views_ch.view3_mask, views_ch.view3_depth} = px[3];
  endtask

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_pixel(input view_t px [MAX_VIEWS]);
    if (!steady && $urandom_range(99) < 6) begin
      views_ch.valid = 1'b0;
      @(negedge clk);
    end
    drive_views(px);
    views_ch.valid = 1'b1;
    do @(posedge clk); while (!views_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_blends();
    views_ch.valid = 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    view_t       px [MAX_VIEWS];
    int          j, p, v;
    logic [2:0]  cnt;
    int unsigned d [MAX_VIEWS];

    sb = new();
    sent = 0;
    steady = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (px[i]) px[i] = '0;
    drive_views(px);
    views_ch.valid = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Walk every mask pair on the two default views; views 2 and 3 must be ignored.
    for (j = 0; j < 20; j++) begin
      foreach (px[i]) px[i] = random_view();
      px[0].mask = j[1:0];
      px[1].mask = j[3:2];
      px[2].mask = MASK_STABLE;
      px[3].mask = MASK_UNSTABLE;
      if (j < 8) begin
        px[0].color = j[0] ? 24'hFFFFFF : 24'h000000;
        px[1].color = j[0] ? 24'h000000 : 24'hFFFFFF;
        px[0].depth = j[1] ? 16'hFFFF : 16'h0000;
        px[1].depth = j[1] ? 16'h0000 : 16'hFFFF;
      end
      if (j >= 16) begin
        px[0].mask = MASK_RESERVED;
        px[1].mask = (j == 16) ? MASK_RESERVED : MASK_STABLE;
      end
      send_pixel(px);
    end
    drain_blends();

    for (p = 0; p < SETTINGS; p++) begin
      foreach (d[i]) d[i] = $urandom_range(0, 65535);
      case (p)
        0: begin cnt = 3'd4; d = '{0, 0, 0, 0}; end
        1: begin cnt = 3'd4; d = '{65535, 65535, 65535, 65535}; end
        2: cnt = 3'd1;
        3: begin cnt = 3'd3; d = '{0, 65535, 1, 256}; end
        4: cnt = 3'd0;
        5: cnt = 3'd7;
        6: begin cnt = 3'd4; d = '{0, 0, 65535, 0}; end
        7: cnt = 3'd2;
        8: begin cnt = 3'd4; foreach (d[i]) d[i] = $urandom_range(0, 1023); end
        default: cnt = 3'($urandom);
      endcase
      apb_write(REG_VIEW_COUNT, DATA_W'(cnt));
      for (v = 0; v < MAX_VIEWS; v++) apb_write(REG_DIST0 + 3'(v), DATA_W'(d[v]));
      steady = (p == 3);
      for (j = 0; j < ITEMS_PER_SETTING; j++) begin
        foreach (px[i]) px[i] = random_view();
        // Hold off mid-setting until the pipeline is empty.
        if (p == 6 && j == ITEMS_PER_SETTING / 2) drain_blends();
        send_pixel(px);
      end
      drain_blends();
    end
    steady = 1'b0;

    repeat (16) @(posedge clk);
    $display("Covered %0d pixels over %0d register settings plus reset defaults:", sent, SETTINGS);
    $display("  %0d clear, %0d single view, %0d weighted blends (%0d plain mean)",
             sb.cleared, sb.passed, sb.blended, sb.flat);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
